// ===== hw/rtl/bee_pkg.sv =====
// Shared types and constants for the button and encoder event qualifier.
// Holds the item and result records, the operation and event codes.
// No dependencies.
package bee_pkg;

	// Field widths fixed by the item and result formats.
	localparam int OP_W   = 2;
	localparam int BTN_W  = 3;
	localparam int POS_W  = 16;
	localparam int NOW_W  = 32;
	localparam int TICK_W = 32;
	localparam int EV_W   = 4;

	// Stream data widths, padded to whole bytes.
	localparam int IN_DATA_W  = 56;
	localparam int OUT_DATA_W = 8;

	// Reset value of the long-press threshold.
	localparam logic [TICK_W-1:0] TICKS_RESET = 32'd1000;

	// Operation carried by each input word.
	typedef enum logic [OP_W-1:0] {
		OP_POLL    = 2'd0,
		OP_DIAL    = 2'd1,
		OP_PRESS   = 2'd2,
		OP_RELEASE = 2'd3
	} op_t;

	// Event codes reported on the output.
	typedef enum logic [EV_W-1:0] {
		EV_NONE = 4'd0,
		EV_INC1 = 4'd1,
		EV_INC2 = 4'd2,
		EV_INC3 = 4'd3,
		EV_DEC1 = 4'd4,
		EV_DEC2 = 4'd5,
		EV_DEC3 = 4'd6,
		EV_DOWN = 4'd7,
		EV_UP   = 4'd8,
		EV_LONG = 4'd9
	} ev_t;

	// One input word after unpacking.
	typedef struct packed {
		op_t              op;
		logic [BTN_W-1:0] button;
		logic [POS_W-1:0] dial_position;
		logic [NOW_W-1:0] now;
	} item_t;

	// One result word.
	typedef struct packed {
		ev_t              ev;
		logic [BTN_W-1:0] button;
	} res_t;

endpackage

// ===== hw/rtl/bee_dial.sv =====
// Rotary encoder step detector: holds the last dial position and turns
// the signed difference to the new one into an increase or decrease event.
// Depends on bee_pkg.
module bee_dial (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   step,
	input  bee_pkg::item_t         item,
	output bee_pkg::ev_t           ev
);
	import bee_pkg::*;

	logic [POS_W-1:0]   last_dial_q;
	logic signed [POS_W:0] diff;
	logic [POS_W-1:0]   mag;
	logic [POS_W-1:0]   half;

	// Signed difference of the two positions, then its halved magnitude.
	always_comb begin
		diff = {last_dial_q[POS_W-1], last_dial_q} -
			{item.dial_position[POS_W-1], item.dial_position};
		mag  = diff[POS_W] ? POS_W'(-diff) : diff[POS_W-1:0];
		half = mag >> 1;
		if (diff == '0) begin
			ev = EV_NONE;
		end else if (diff[POS_W]) begin
			ev = (half == POS_W'(1)) ? EV_INC1 : (half == POS_W'(2)) ? EV_INC2 : EV_INC3;
		end else begin
			ev = (half == POS_W'(1)) ? EV_DEC1 : (half == POS_W'(2)) ? EV_DEC2 : EV_DEC3;
		end
	end

	// Every dial word replaces the stored position.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_dial_q <= '0;
		end else if (step && item.op == OP_DIAL) begin
			last_dial_q <= item.dial_position;
		end
	end

endmodule

// ===== hw/rtl/bee_buttons.sv =====
// Button press table and long-press scan: per-button press time and
// reported flag, parallel elapsed-time compares and a lowest-index pick.
// Depends on bee_pkg.
module bee_buttons #(
	parameter int NUM_BUTTONS = 6,
	parameter int TIME_BITS   = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        step,
	input  bee_pkg::item_t              item,
	input  logic [bee_pkg::TICK_W-1:0]  long_press_ticks,
	output bee_pkg::res_t               res
);
	import bee_pkg::*;

	localparam int CMP_W  = (TIME_BITS > NOW_W) ? TIME_BITS : NOW_W;
	localparam int BIDX_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

	logic [TIME_BITS-1:0]   press_time_q [NUM_BUTTONS];
	logic [NUM_BUTTONS-1:0] long_reported_q;

	logic [CMP_W-1:0]       now_ext;
	logic [TIME_BITS-1:0]   now_m;
	logic [TIME_BITS-1:0]   elapsed [NUM_BUTTONS];
	logic [NUM_BUTTONS-1:0] hit;
	logic                   found;
	logic [BIDX_W-1:0]      idx;
	logic                   btn_ok;

	// Time masked to the table width.
	always_comb begin
		now_ext = CMP_W'(item.now);
		now_m   = now_ext[TIME_BITS-1:0];
		btn_ok  = (32'(item.button) < NUM_BUTTONS);
	end

	// Elapsed-time compare for every button, then the lowest candidate wins.
	always_comb begin
		found = 1'b0;
		idx   = '0;
		for (int i = 0; i < NUM_BUTTONS; i++) begin
			elapsed[i] = now_m - press_time_q[i];
			hit[i] = (press_time_q[i] != '0) && !long_reported_q[i] &&
				(CMP_W'(elapsed[i]) > CMP_W'(long_press_ticks));
		end
		for (int i = NUM_BUTTONS - 1; i >= 0; i--) begin
			if (hit[i]) begin
				found = 1'b1;
				idx   = BIDX_W'(i);
			end
		end
	end

	// Result for poll, press and release words.
	always_comb begin
		res.ev     = EV_NONE;
		res.button = '0;
		unique case (item.op)
			OP_POLL: begin
				if (found) begin
					res.ev     = EV_LONG;
					res.button = BTN_W'(idx);
				end
			end
			OP_PRESS: begin
				if (btn_ok) begin
					res.ev     = EV_DOWN;
					res.button = item.button;
				end
			end
			OP_RELEASE: begin
				if (btn_ok) begin
					res.ev     = EV_UP;
					res.button = item.button;
				end
			end
			OP_DIAL: begin
				res.ev     = EV_NONE;
				res.button = '0;
			end
			default: begin
				res.ev     = EV_NONE;
				res.button = '0;
			end
		endcase
	end

	// Table update: a long press marks its button, press and release rewrite it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_BUTTONS; i++) begin
				press_time_q[i]    <= '0;
				long_reported_q[i] <= 1'b0;
			end
		end else if (step) begin
			for (int i = 0; i < NUM_BUTTONS; i++) begin
				if (item.op == OP_POLL && found && idx == BIDX_W'(i)) begin
					long_reported_q[i] <= 1'b1;
				end
				if ((item.op == OP_PRESS || item.op == OP_RELEASE) && btn_ok &&
					32'(item.button) == i) begin
					long_reported_q[i] <= 1'b0;
					press_time_q[i]    <= (item.op == OP_PRESS) ? now_m : '0;
				end
			end
		end
	end

endmodule

// ===== hw/rtl/button_encoder_event_qualifier.sv =====
// Top level of the button and rotary encoder event qualifier.
// Instantiates bee_buttons and bee_dial; depends on bee_pkg.
//
//  channel   dir  tdata (low bit up)                          tuser
//  s_*       in   button[2:0], dial_position[18:3], now[50:19] op[1:0]
//  m_*       out  event_button[2:0]                            event_res[3:0]
//  cfg_*     in   cfg_wdata = long_press_ticks                 -
//
// Each word is registered on entry and its result is computed combinationally
// into the output register, so one word per cycle is sustained while the
// output is not stalled. The critical path is the six-way elapsed-time
// compare with its priority pick. Reset clears the press table and the dial
// position and sets the threshold to 1000. A stalled output holds its word while
// one further word waits in the entry register.
module button_encoder_event_qualifier #(
	parameter int NUM_BUTTONS = 6,
	parameter int TIME_BITS   = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// button[2:0], dial_position[18:3], now[50:19], zero fill above
	input  logic [bee_pkg::IN_DATA_W-1:0]     s_tdata,
	// op[1:0]
	input  logic [bee_pkg::OP_W-1:0]          s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// event_button[2:0], zero fill above
	output logic [bee_pkg::OUT_DATA_W-1:0]    m_tdata,
	// event_res[3:0]
	output logic [bee_pkg::EV_W-1:0]          m_tuser,
	input  logic                              cfg_we,
	input  logic [bee_pkg::TICK_W-1:0]        cfg_wdata
);
	import bee_pkg::*;

	item_t             item_s1;
	logic              valid_s1;
	res_t              res_q;
	logic              out_valid_q;
	logic [TICK_W-1:0] ticks_q;

	item_t             in_item;
	logic              s_fire;
	logic              advance;
	res_t              btn_res;
	ev_t               dial_ev;
	res_t              res_next;

	// Unpack the incoming word.
	always_comb begin
		in_item.op            = op_t'(s_tuser);
		in_item.button        = s_tdata[BTN_W-1:0];
		in_item.dial_position = s_tdata[BTN_W+POS_W-1:BTN_W];
		in_item.now           = s_tdata[BTN_W+POS_W+NOW_W-1:BTN_W+POS_W];
	end

	// Handshake: the entry word moves on whenever the output register is free.
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign s_fire   = s_tvalid && s_tready;

	// Long-press threshold register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticks_q <= TICKS_RESET;
		end else if (cfg_we) begin
			ticks_q <= cfg_wdata;
		end
	end

	// Entry register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_fire) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			item_s1 <= in_item;
		end
	end

	bee_buttons #(
		.NUM_BUTTONS (NUM_BUTTONS),
		.TIME_BITS   (TIME_BITS)
	) u_buttons (
		.clk              (clk),
		.arst_n           (arst_n),
		.step             (advance),
		.item             (item_s1),
		.long_press_ticks (ticks_q),
		.res              (btn_res)
	);

	bee_dial u_dial (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.ev     (dial_ev)
	);

	// Select the result by operation.
	always_comb begin
		if (item_s1.op == OP_DIAL) begin
			res_next.ev     = dial_ev;
			res_next.button = '0;
		end else begin
			res_next = btn_res;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_next;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_DATA_W'(res_q.button);
	assign m_tuser  = res_q.ev;

endmodule

// ===== tb/bee_event_checker.sv =====
// Scoreboard for the button and rotary encoder event qualifier.
// Watches the input, output and threshold ports, predicts each result word and compares.
// Depends on bee_pkg for the word layouts and the operation and event codes.
module bee_event_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	input  logic                           s_tready,
	input  logic [bee_pkg::IN_DATA_W-1:0]  s_tdata,
	input  logic [bee_pkg::OP_W-1:0]       s_tuser,
	input  logic                           m_tvalid,
	input  logic                           m_tready,
	input  logic [bee_pkg::OUT_DATA_W-1:0] m_tdata,
	input  logic [bee_pkg::EV_W-1:0]       m_tuser,
	input  logic                           cfg_we,
	input  logic [bee_pkg::TICK_W-1:0]     cfg_wdata,
	output int                             fail_count,
	output int                             pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import bee_pkg::*;

	localparam int BUTTONS = 6;

	// Mirror of the block state: threshold, press table and last dial position.
	logic [TICK_W-1:0] hold_ticks;
	logic [NOW_W-1:0]  press_at [BUTTONS];
	logic              long_done [BUTTONS];
	logic [POS_W-1:0]  dial_last;
	res_t              expected_events [$];
	int                errors;

	initial begin
		fail_count = 0;
		pending = 0;
		errors = 0;
	end

	// Works out the event for one input word and updates the mirrored state.
	function automatic res_t qualify_event(item_t it);
		res_t        r;
		int          delta;
		int          half;
		int          steps;
		logic        hit;
		r.ev = EV_NONE;
		r.button = '0;
		hit = 1'b0;
		case (it.op)
			OP_POLL: begin
				// Lowest held, not yet reported button past the threshold wins.
				for (int i = 0; i < BUTTONS; i++) begin
					if (!hit && press_at[i] != '0 && !long_done[i] &&
							(it.now - press_at[i]) > hold_ticks) begin
						hit = 1'b1;
						long_done[i] = 1'b1;
						r.ev = EV_LONG;
						r.button = BTN_W'(i);
					end
				end
			end
			OP_DIAL: begin
				// Signed difference without wrap; a halved size of zero counts as three steps.
				delta = int'($signed(dial_last)) - int'($signed(it.dial_position));
				dial_last = it.dial_position;
				if (delta != 0) begin
					half = (delta < 0 ? -delta : delta) / 2;
					steps = (half == 1) ? 0 : (half == 2) ? 1 : 2;
					r.ev = ev_t'(int'(delta < 0 ? EV_INC1 : EV_DEC1) + steps);
				end
			end
			default: begin
				// Press or release; buttons past the table are ignored.
				if (int'(it.button) < BUTTONS) begin
					long_done[it.button] = 1'b0;
					if (it.op == OP_PRESS) begin
						press_at[it.button] = it.now;
						r.ev = EV_DOWN;
					end else begin
						press_at[it.button] = '0;
						r.ev = EV_UP;
					end
					r.button = it.button;
				end
			end
		endcase
		return r;
	endfunction

	// Compare each result word with the oldest prediction, then predict for new input words.
	always @(posedge clk or negedge arst_n) begin
		item_t it;
		res_t  want;
		if (!arst_n) begin
			hold_ticks = TICKS_RESET;
			for (int i = 0; i < BUTTONS; i++) begin
				press_at[i] = '0;
				long_done[i] = 1'b0;
			end
			dial_last = '0;
			expected_events.delete();
			pending <= 0;
		end else begin
			if (cfg_we)
				hold_ticks = cfg_wdata;
			if (m_tvalid && m_tready) begin
				if (expected_events.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected result word: ev %0d button %0d", m_tuser,
							m_tdata[BTN_W-1:0]);
				end else begin
					want = expected_events.pop_front();
					if (m_tuser != want.ev || m_tdata[BTN_W-1:0] != want.button) begin
						errors++;
						if (errors <= 10)
							$display("mismatch: expected ev %0d button %0d, got ev %0d button %0d",
								want.ev, want.button, m_tuser, m_tdata[BTN_W-1:0]);
					end
				end
			end
			if (s_tvalid && s_tready) begin
				it.op = op_t'(s_tuser);
				it.button = s_tdata[BTN_W-1:0];
				it.dial_position = s_tdata[BTN_W +: POS_W];
				it.now = s_tdata[BTN_W+POS_W +: NOW_W];
				expected_events.push_back(qualify_event(it));
			end
			pending <= expected_events.size();
			fail_count <= errors;
		end
	end

endmodule

// ===== tb/tb_button_encoder_event_qualifier.sv =====
// Top of the testbench for the button and rotary encoder event qualifier.
// Drives directed and random input words and threshold writes; bee_event_checker judges results.
// Depends on bee_pkg, button_encoder_event_qualifier and bee_event_checker.
module tb_button_encoder_event_qualifier;
	timeunit 1ns;
	timeprecision 1ps;
	import bee_pkg::*;

	localparam int RANDOM_WORDS = 1200;
	localparam int PHASES = 5;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic [OP_W-1:0]       s_tuser = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [EV_W-1:0]       m_tuser;
	logic                  cfg_we = 1'b0;
	logic [TICK_W-1:0]     cfg_wdata = '0;
	int                    fail_count;
	int                    pending;

	// Stimulus state: no-stall stretch, running tick count, last dial position sent.
	logic                  steady = 1'b0;
	logic [NOW_W-1:0]      tick;
	logic [POS_W-1:0]      dial_at = '0;

	always #5 clk = ~clk;

	button_encoder_event_qualifier dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	bee_event_checker events_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// The receiver stalls at random, about 15 percent of the time, outside the steady stretch.
	always @(posedge clk) begin
		m_tready <= steady || ($urandom_range(99) >= 15);
	end

	// Sends one input word, sometimes after a gap with valid low, and waits for the handshake.
	task automatic send_word(op_t op, logic [BTN_W-1:0] btn, logic [POS_W-1:0] pos,
			logic [NOW_W-1:0] now_v);
		if (!steady && $urandom_range(99) < 18) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= IN_DATA_W'({now_v, pos, btn});
		if (op == OP_DIAL)
			dial_at = pos;
		do @(posedge clk); while (!s_tready);
	endtask

	// Stops sending and waits until every predicted word has come out.
	task automatic drain_events();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_threshold(logic [TICK_W-1:0] value);
		drain_events();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Mostly plausible presses, releases, polls and small dial moves, with some noise.
	task automatic send_random_input();
		int               pick;
		logic [BTN_W-1:0] btn;
		logic [POS_W-1:0] step;
		pick = $urandom_range(99);
		btn = ($urandom_range(9) == 0) ? BTN_W'($urandom_range(6, 7)) :
			BTN_W'($urandom_range(0, 5));
		step = POS_W'(int'($urandom_range(0, 16)) - 8);
		tick = tick + NOW_W'($urandom_range(0, 40));
		if (pick < 25)
			send_word(OP_PRESS, btn, POS_W'($urandom), tick);
		else if (pick < 45)
			send_word(OP_RELEASE, btn, POS_W'($urandom), tick);
		else if (pick < 70)
			send_word(OP_POLL, BTN_W'($urandom), POS_W'($urandom), tick);
		else if (pick < 90)
			send_word(OP_DIAL, BTN_W'($urandom), dial_at + step, tick);
		else
			send_word(op_t'($urandom_range(0, 3)), BTN_W'($urandom), POS_W'($urandom),
				NOW_W'($urandom));
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Long-press rules at the reset threshold of 1000.
		send_word(OP_POLL, 3'd0, 16'd0, 32'd500);
		send_word(OP_PRESS, 3'd0, 16'd0, 32'd0);
		// A press at tick zero is never seen as held.
		send_word(OP_POLL, 3'd0, 16'd0, 32'd5000);
		send_word(OP_PRESS, 3'd5, 16'd0, 32'd100);
		// Exactly the threshold is not enough; one more tick is.
		send_word(OP_POLL, 3'd0, 16'd0, 32'd1100);
		send_word(OP_POLL, 3'd0, 16'd0, 32'd1101);
		// Buttons past the table do nothing.
		send_word(OP_PRESS, 3'd6, 16'hFFFF, 32'd7);
		send_word(OP_RELEASE, 3'd7, 16'hFFFF, 32'hFFFF_FFFF);
		// Elapsed time across the tick wrap, then priority between two held buttons.
		send_word(OP_PRESS, 3'd2, 16'd0, 32'hFFFF_FFF0);
		send_word(OP_PRESS, 3'd3, 16'd0, 32'd10);
		send_word(OP_POLL, 3'd0, 16'd0, 32'd1024);
		send_word(OP_POLL, 3'd0, 16'd0, 32'd1024);
		// Releases answer up whether or not the button is held.
		send_word(OP_RELEASE, 3'd2, 16'd0, 32'd1030);
		send_word(OP_RELEASE, 3'd2, 16'd0, 32'd1031);
		send_word(OP_RELEASE, 3'd4, 16'd0, 32'd1032);
		// A second press restarts the hold time.
		send_word(OP_PRESS, 3'd1, 16'd0, 32'd50);
		send_word(OP_PRESS, 3'd1, 16'd0, 32'd2000);
		send_word(OP_POLL, 3'd0, 16'd0, 32'd2500);
		send_word(OP_POLL, 3'd0, 16'd0, 32'd3001);

		// Dial steps, no movement, a halved size of zero, and the signed extremes.
		send_word(OP_DIAL, 3'd0, 16'd2, 32'd0);
		send_word(OP_DIAL, 3'd0, 16'd6, 32'd0);
		send_word(OP_DIAL, 3'd0, 16'd7, 32'd0);
		send_word(OP_DIAL, 3'd0, 16'd7, 32'd0);
		send_word(OP_DIAL, 3'd0, 16'd1, 32'd0);
		send_word(OP_DIAL, 3'd0, 16'hFFFF, 32'd0);
		send_word(OP_DIAL, 3'd0, 16'h7FFF, 32'd0);
		send_word(OP_DIAL, 3'd0, 16'h8000, 32'd0);
		send_word(OP_DIAL, 3'd0, 16'h7FFF, 32'd0);
		send_word(OP_DIAL, 3'd0, 16'h7FFD, 32'd0);
		send_word(OP_DIAL, 3'd0, 16'h7FF9, 32'd0);

		// Random phases, each under its own threshold, the extremes among them.
		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: write_threshold(TICK_W'($urandom_range(0, 60)));
				1: write_threshold('0);
				2: write_threshold('1);
				3: write_threshold(TICK_W'($urandom_range(1, 200)));
				default: write_threshold(TICK_W'($urandom));
			endcase
			tick = (phase == 3) ? 32'hFFFF_FE00 : NOW_W'($urandom_range(0, 3));
			for (int n = 0; n < RANDOM_WORDS / PHASES; n++) begin
				steady <= (phase == 1 && n >= 40 && n < 200);
				send_random_input();
			end
		end
		drain_events();

		if (fail_count == 0 && pending == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	// Give up well past the slowest correct run.
	initial begin
		#2_000_000;
		$display("FAIL");
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/bee_pkg.sv
hw/rtl/bee_dial.sv
hw/rtl/bee_buttons.sv
hw/rtl/button_encoder_event_qualifier.sv
tb/bee_event_checker.sv
tb/tb_button_encoder_event_qualifier.sv
